@@ rtl/core/spcc_pkg.sv @@
// Package for the sensor packet CRC checker: status codes, register
// indexes, result struct and the byte-wide CRC-16/CCITT update function.
// No dependencies.
`default_nettype none

package spcc_pkg;

    // CRC-16/CCITT constants (MSB first, no final xor)
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_VALUE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_BIG_E = 8'd1;

    // Packet status codes
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_LENGTH  = 2'd1,
        STATUS_BAD_MAGIC   = 2'd2,
        STATUS_BAD_CRC     = 2'd3
    } status_t;

    // One result beat
    typedef struct packed {
        status_t     status;
        logic [15:0] computed_crc;
    } result_t;

    // Unrolled 8-bit CRC update, one shift per data bit
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/spcc_tracker.sv @@
// Per-packet tracker: byte counter, running CRC, magic check, held checksum
// byte and the status decision on the last byte. Uses spcc_pkg.
`default_nettype none

module spcc_tracker #(
    parameter int unsigned PACKET_BYTES = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 beat_accept,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 last_byte,
    input  wire logic [7:0]           magic_value,
    input  wire logic                 checksum_big_endian,
    output logic                      res_valid,
    output spcc_pkg::result_t         res
);

    localparam int unsigned CNT_W = $clog2(PACKET_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(PACKET_BYTES);
    localparam logic [CNT_W-1:0] POS_HELD  = CNT_W'(PACKET_BYTES - 2);
    localparam logic [CNT_W-1:0] POS_FINAL = CNT_W'(PACKET_BYTES - 1);

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]      crc_reg, crc_next;
    logic             magic_bad_reg, magic_bad_next;
    logic [7:0]       held_reg;
    logic [15:0]      received;
    logic [15:0]      crc_upd;

    assign crc_upd = spcc_pkg::crc_byte(crc_reg, data_byte);

    // Per-byte update of the packet state
    always_comb begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        magic_bad_next  = magic_bad_reg;
        if (byte_count_reg == '0) begin
            magic_bad_next = (data_byte != magic_value);
        end
        if (byte_count_reg < POS_HELD) begin
            crc_next = crc_upd;
        end
        if (!last_byte && byte_count_reg < CNT_MAX) begin
            byte_count_next = byte_count_reg + 1'b1;
        end
    end

    // Received checksum assembly
    assign received = checksum_big_endian ? {held_reg, data_byte}
                                          : {data_byte, held_reg};

    // Status decision for the flagged byte
    always_comb begin
        res_valid        = beat_accept && last_byte;
        res.computed_crc = crc_next;
        if (byte_count_reg != POS_FINAL) begin
            res.status = spcc_pkg::STATUS_BAD_LENGTH;
        end else if (magic_bad_next) begin
            res.status = spcc_pkg::STATUS_BAD_MAGIC;
        end else if (crc_next != received) begin
            res.status = spcc_pkg::STATUS_BAD_CRC;
        end else begin
            res.status = spcc_pkg::STATUS_OK;
        end
    end

    // Packet state registers, cleared after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            crc_reg        <= spcc_pkg::CRC_INIT;
            magic_bad_reg  <= 1'b0;
        end else if (beat_accept) begin
            if (last_byte) begin
                byte_count_reg <= '0;
                crc_reg        <= spcc_pkg::CRC_INIT;
                magic_bad_reg  <= 1'b0;
            end else begin
                byte_count_reg <= byte_count_next;
                crc_reg        <= crc_next;
                magic_bad_reg  <= magic_bad_next;
            end
        end
    end

    // First checksum byte, no reset needed
    always_ff @(posedge aclk) begin
        if (beat_accept && byte_count_reg == POS_HELD) begin
            held_reg <= data_byte;
        end
    end

    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= CNT_MAX)
        else $error("byte counter beyond packet length");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_accept && last_byte |=> byte_count_reg == '0 &&
                                     crc_reg == spcc_pkg::CRC_INIT && !magic_bad_reg)
        else $error("packet state not cleared after last beat");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !beat_accept |=> $stable(byte_count_reg) && $stable(crc_reg))
        else $error("packet state moved without a beat");

endmodule

`default_nettype wire

@@ rtl/core/spcc_out_buf.sv @@
// Two-entry result buffer: output register plus skid entry, so input beats
// keep flowing while a result waits. Uses spcc_pkg.
`default_nettype none

module spcc_out_buf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               res_valid,
    input  wire spcc_pkg::result_t  res,
    output logic                    in_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output spcc_pkg::result_t       m_res
);

    logic              out_valid_reg, out_valid_next;
    spcc_pkg::result_t out_reg, out_next;
    logic              sk_valid_reg, sk_valid_next;
    spcc_pkg::result_t sk_reg, sk_next;
    logic              out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign in_ready = !sk_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_res    = out_reg;

    // Buffer steering
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        sk_valid_next  = sk_valid_reg;
        sk_next        = sk_reg;
        if (out_free) begin
            if (sk_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = sk_reg;
                sk_valid_next  = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end else if (res_valid) begin
            sk_valid_next = 1'b1;
            sk_next       = res;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            sk_valid_reg  <= sk_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        sk_reg  <= sk_next;
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output empty");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !sk_valid_reg)
        else $error("result arrived with buffer full");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_valid_reg && m_ready |=> out_valid_reg && !sk_valid_reg)
        else $error("skid entry not moved to output");

endmodule

`default_nettype wire

@@ rtl/core/sensor_packet_crc_checker_top.sv @@
// Sensor packet CRC checker, top level: configuration registers, packet
// tracker and result buffer. Uses spcc_pkg, spcc_tracker, spcc_out_buf.
//
// Takes one packet byte per clock cycle while s_ready is high and checks
// packets of PACKET_BYTES bytes: CRC-16/CCITT (poly 0x1021, init 0xFFFF)
// over all but the last two bytes, which carry the received checksum, and
// the first byte against magic_value. On the beat flagged s_last_byte one
// result beat carries the status (wrong length, bad magic, checksum
// mismatch, ok, in that priority) and the computed CRC. Throughput is one
// byte per cycle, set by the unrolled byte-wide CRC update; results go
// through a two-entry output buffer, and s_ready drops only while both
// entries hold results that m_ready has not taken. Write configuration
// only while no packet is in flight; cfg_ready is always high.
`default_nettype none

module sensor_packet_crc_checker_top #(
    parameter int unsigned PACKET_BYTES = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // byte input
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_data_byte,
    input  wire logic                           s_last_byte,
    // result output
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [1:0]                          m_status,
    output logic [15:0]                         m_computed_crc,
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [spcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data
);

    logic [7:0]        magic_reg;
    logic              big_endian_reg;
    logic              beat_accept;
    logic              res_valid;
    spcc_pkg::result_t res;
    spcc_pkg::result_t m_res;
    logic              buf_ready;

    assign cfg_ready   = 1'b1;
    assign s_ready     = buf_ready;
    assign beat_accept = s_valid && buf_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg      <= 8'h00;
            big_endian_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                spcc_pkg::CFG_MAGIC_VALUE:    magic_reg      <= cfg_data;
                spcc_pkg::CFG_CHECKSUM_BIG_E: big_endian_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    spcc_tracker #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_tracker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .beat_accept         (beat_accept),
        .data_byte           (s_data_byte),
        .last_byte           (s_last_byte),
        .magic_value         (magic_reg),
        .checksum_big_endian (big_endian_reg),
        .res_valid           (res_valid),
        .res                 (res)
    );

    spcc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (buf_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_status       = m_res.status;
    assign m_computed_crc = m_res.computed_crc;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for sensor_packet_crc_checker_top: directed packet table,
// then random packets over several register settings, scored by a packet-state predictor.
// Depends on spcc_pkg and the RTL under rtl/core.
`default_nettype none

module tb;
    import spcc_pkg::*;

    localparam int PKT_LEN        = 16;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEMS_PER_SET  = 250;
    localparam int NUM_SETS       = 5;
    localparam int HOLD_OFF_CYCLES = 400;

    // kinds of directed rows: a plain byte, or a checksum byte filled in from the CRC so far
    typedef enum {ROW_BYTE, ROW_CKSUM_FIRST, ROW_CKSUM_SECOND} row_kind_e;

    typedef struct {
        logic [7:0] data;
        bit         last;
        row_kind_e  kind;
        bit         typed;
        status_t    typed_status;
    } dir_row_t;

    typedef enum {PKT_GOOD, PKT_BAD_MAGIC, PKT_BAD_CRC, PKT_SHORT, PKT_LONG, PKT_NOISE} pkt_kind_e;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_data_byte;
    logic                 s_last_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_status;
    logic [15:0]          m_computed_crc;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    sensor_packet_crc_checker_top #(
        .PACKET_BYTES(PKT_LEN)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data_byte(s_data_byte),
        .s_last_byte(s_last_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_computed_crc(m_computed_crc),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock, period 12
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // packet tracker copy and register shadow
    logic [15:0] pkt_crc;
    int          pkt_pos;
    bit          pkt_magic_bad;
    logic [7:0]  held_cksum;
    logic [7:0]  shadow_magic;
    bit          shadow_big_endian;

    result_t     pending_results[$];
    dir_row_t    directed_rows[$];
    int          err_count = 0;
    int          cycle_count = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    bit          hold_off_request = 1'b0;

    // bit-serial CRC-16/CCITT, feeding one data bit per shift
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    // advance the packet tracker by one byte; returns 1 with the result on a last beat
    function automatic bit track_byte(input logic [7:0] b, input bit last, output result_t res);
        logic [15:0] rx_cksum;
        int          pos;
        pos = pkt_pos;
        res = '0;
        if (pos == 0)
            pkt_magic_bad = (b != shadow_magic);
        if (pos < PKT_LEN - 2)
            pkt_crc = crc16_feed(pkt_crc, b);
        else if (pos == PKT_LEN - 2)
            held_cksum = b;
        if (!last) begin
            if (pkt_pos < PKT_LEN)
                pkt_pos++;
            return 1'b0;
        end
        rx_cksum = shadow_big_endian ? {held_cksum, b} : {b, held_cksum};
        if (pos != PKT_LEN - 1)
            res.status = STATUS_BAD_LENGTH;
        else if (pkt_magic_bad)
            res.status = STATUS_BAD_MAGIC;
        else if (pkt_crc != rx_cksum)
            res.status = STATUS_BAD_CRC;
        else
            res.status = STATUS_OK;
        res.computed_crc = pkt_crc;
        pkt_crc       = CRC_INIT;
        pkt_pos       = 0;
        pkt_magic_bad = 1'b0;
        return 1'b1;
    endfunction

    // correct checksum byte for the current packet, in the configured order
    function automatic logic [7:0] cksum_byte(input bit second);
        if (shadow_big_endian)
            return second ? pkt_crc[7:0] : pkt_crc[15:8];
        return second ? pkt_crc[15:8] : pkt_crc[7:0];
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic void add_row(input logic [7:0] d, input bit l, input row_kind_e k,
                                    input bit t, input status_t st);
        dir_row_t r;
        r.data = d;
        r.last = l;
        r.kind = k;
        r.typed = t;
        r.typed_status = st;
        directed_rows.push_back(r);
    endfunction

    // one input beat; called at a rising edge, returns at the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                             input status_t typed_status);
        int      gap;
        result_t res;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        if (track_byte(b, last, res)) begin
            if (typed)
                res.status = typed_status;
            pending_results.push_back(res);
        end
    endtask

    // drain: stop offering, wait for all results, let the pipeline empty
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_MAGIC_VALUE)
            shadow_magic = val;
        else if (idx == CFG_CHECKSUM_BIG_E)
            shadow_big_endian = val[0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // one random packet: mostly well-formed, some broken, some noise
    task automatic send_random_packet(output int sent);
        int         draw;
        int         len;
        int         bad_slot;
        logic [7:0] flip;
        logic [7:0] b;
        bit         lst;
        pkt_kind_e  kind;
        if ($urandom_range(0, 9) == 0)
            tx_burst = !tx_burst;
        draw = $urandom_range(0, 99);
        if (draw < 50)      kind = PKT_GOOD;
        else if (draw < 60) kind = PKT_BAD_MAGIC;
        else if (draw < 70) kind = PKT_BAD_CRC;
        else if (draw < 80) kind = PKT_SHORT;
        else if (draw < 88) kind = PKT_LONG;
        else                kind = PKT_NOISE;
        case (kind)
            PKT_SHORT: len = $urandom_range(1, PKT_LEN - 1);
            PKT_LONG:  len = $urandom_range(PKT_LEN + 1, PKT_LEN + 24);
            PKT_NOISE: len = $urandom_range(1, 24);
            default:   len = PKT_LEN;
        endcase
        bad_slot = $urandom_range(PKT_LEN - 2, PKT_LEN - 1);
        flip = $urandom_range(1, 255);
        sent = 0;
        for (int i = 0; i < len; i++) begin
            b   = $urandom_range(0, 255);
            lst = (i == len - 1);
            if (kind == PKT_NOISE && $urandom_range(0, 3) == 0)
                lst = 1'b1;
            if (i == 0 && kind != PKT_NOISE)
                b = (kind == PKT_BAD_MAGIC) ? (shadow_magic ^ flip) : shadow_magic;
            if ((kind == PKT_GOOD || kind == PKT_BAD_MAGIC || kind == PKT_BAD_CRC)
                    && i >= PKT_LEN - 2) begin
                b = cksum_byte(i == PKT_LEN - 1);
                if (kind == PKT_BAD_CRC && i == bad_slot)
                    b = b ^ flip;
            end
            send_byte(b, lst, 1'b0, STATUS_OK);
            sent++;
            if (lst)
                break;
        end
    endtask

    // cycle counter and run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random ready gaps, one long hold-off on request, scoreboard check
    initial begin
        int      gap;
        result_t exp_res;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 7) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 6);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                gap = HOLD_OFF_CYCLES;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d crc %04h",
                                          m_status, m_computed_crc));
            end else begin
                exp_res = pending_results.pop_front();
                if (m_status !== exp_res.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_status, exp_res.status));
                if (m_computed_crc !== exp_res.computed_crc)
                    report_mismatch($sformatf("computed_crc %04h, expected %04h",
                                              m_computed_crc, exp_res.computed_crc));
            end
        end
    end

    // stimulus
    initial begin
        int         sent;
        int         set_items;
        logic [7:0] b;
        logic [7:0] set_magic;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data_byte <= 8'h00;
        s_last_byte <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= 8'h00;
        pkt_crc           = CRC_INIT;
        pkt_pos           = 0;
        pkt_magic_bad     = 1'b0;
        held_cksum        = 8'h00;
        shadow_magic      = 8'h00;
        shadow_big_endian = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-byte packet: magic fails too, but length wins
        add_row(8'hFF, 1'b1, ROW_BYTE, 1'b1, STATUS_BAD_LENGTH);
        // short packet with wrong magic
        add_row(8'hAA, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'h55, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'h00, 1'b1, ROW_BYTE, 1'b1, STATUS_BAD_LENGTH);
        // full packet at reset settings: magic 0, checksum low byte first
        add_row(8'h00, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'hFF, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'h00, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'h80, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'h01, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'h7F, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'hFE, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'h55, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'hAA, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'h0F, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'hF0, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'h33, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'hCC, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'h81, 1'b0, ROW_BYTE, 1'b0, STATUS_OK);
        add_row(8'h00, 1'b0, ROW_CKSUM_FIRST, 1'b0, STATUS_OK);
        add_row(8'h00, 1'b1, ROW_CKSUM_SECOND, 1'b1, STATUS_OK);

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_CKSUM_FIRST:  b = cksum_byte(1'b0);
                ROW_CKSUM_SECOND: b = cksum_byte(1'b1);
                default:          b = directed_rows[i].data;
            endcase
            send_byte(b, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].typed_status);
        end
        settle_idle();

        // random packets under several register settings, extremes first
        for (int set_no = 0; set_no < NUM_SETS; set_no++) begin
            case (set_no)
                0:       set_magic = 8'hFF;
                1:       set_magic = 8'h00;
                default: set_magic = $urandom_range(0, 255);
            endcase
            write_reg(CFG_MAGIC_VALUE, set_magic);
            write_reg(CFG_CHECKSUM_BIG_E, {7'd0, ~set_no[0]});
            // one long receiver hold-off while bytes keep coming
            if (set_no == 2)
                hold_off_request = 1'b1;
            set_items = 0;
            while (set_items < ITEMS_PER_SET) begin
                send_random_packet(sent);
                set_items += sent;
            end
            settle_idle();
        end

        repeat (8) @(posedge aclk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
